>>> sv/rbb_pkg.sv
// shared types, constants and the backoff multiplier table for the restart budget block
// no dependencies; imported by every module of the block

package rbb_pkg;

  localparam int TIME_BITS         = 48;
  localparam int RECORD_DEPTH_DEF  = 16;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_INDEX_W       = 2;
  localparam int DELAY_W           = 26;
  localparam int COUNT_W           = 16;
  localparam int MS_PER_S          = 1000;
  localparam int MULT_LAST         = 5;

  localparam logic [4:0]  MAX_RESTARTS_RST = 5'd5;
  localparam logic [31:0] WINDOW_MS_RST    = 32'd60000;
  localparam logic [15:0] BACKOFF_RST      = 16'd1;
  localparam logic [15:0] MAX_BACKOFF_RST  = 16'd300;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_RESTARTS = 2'd0,
    REG_WINDOW_MS    = 2'd1,
    REG_BACKOFF      = 2'd2,
    REG_MAX_BACKOFF  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  typedef struct packed {
    logic                 operation;
    logic [TIME_BITS-1:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic               granted;
    logic [DELAY_W-1:0] delay_ms;
    logic [COUNT_W-1:0] attempt_count;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_PRUNE,
    S_DECIDE,
    S_SCALE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clear;
    logic set_thr;
    logic pop;
    logic mul;
    logic commit;
    logic refuse;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic prune_done;
    logic full;
  } dp_status_t;

  // exponential multiplier, flat beyond the last step
  function automatic logic [4:0] backoff_mult(input logic [2:0] idx);
    logic [4:0] m;
    case (idx)
      3'd0:    m = 5'd1;
      3'd1:    m = 5'd2;
      3'd2:    m = 5'd4;
      3'd3:    m = 5'd8;
      3'd4:    m = 5'd15;
      default: m = 5'd30;
    endcase
    return m;
  endfunction

endpackage

>>> sv/rbb_ctrl.sv
// sequencer for the restart budget block: accept, clear or prune, decide, scale, respond
// depends on rbb_pkg

module rbb_ctrl
  import rbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        if (status.op_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.set_thr = 1'b1;
          state_nxt   = S_PRUNE;
        end
      end
      S_PRUNE: begin
        if (status.prune_done) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      S_DECIDE: begin
        if (status.full) begin
          cmd.refuse = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/rbb_dpath.sv
// datapath for the restart budget block: config registers, grant time ring,
// window threshold, backoff multiply and the output register; depends on rbb_pkg

module rbb_dpath
  import rbb_pkg::*;
#(
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  in_req_t                in_data,
  output out_req_t               out_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status
);

  localparam int IDX_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int CNT_W = $clog2(RECORD_DEPTH + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RECORD_DEPTH - 1);

  // configuration
  logic [4:0]  max_restarts_r;
  logic [31:0] window_ms_r;
  logic [15:0] backoff_r;
  logic [15:0] max_backoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_restarts_r <= MAX_RESTARTS_RST;
      window_ms_r    <= WINDOW_MS_RST;
      backoff_r      <= BACKOFF_RST;
      max_backoff_r  <= MAX_BACKOFF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RESTARTS: max_restarts_r <= cfg_data[4:0];
        REG_WINDOW_MS:    window_ms_r    <= cfg_data;
        REG_BACKOFF:      backoff_r      <= cfg_data[15:0];
        REG_MAX_BACKOFF:  max_backoff_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // request latch
  logic                 op_r;
  logic [TIME_BITS-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.operation;
      now_r <= in_data.now_ms;
    end
  end

  // ring control
  logic [IDX_W-1:0] oldest_r, tail_r;
  logic [CNT_W-1:0] count_r;
  logic [15:0]      grants_r;
  logic [IDX_W-1:0] oldest_inc, tail_inc, rd_addr;

  assign oldest_inc = (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
  assign tail_inc   = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      oldest_r <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      grants_r <= '0;
    end else if (cmd.pop) begin
      oldest_r <= oldest_inc;
      count_r  <= count_r - 1'b1;
    end else if (cmd.commit) begin
      tail_r   <= tail_inc;
      count_r  <= count_r + 1'b1;
      if (grants_r != 16'hFFFF) begin
        grants_r <= grants_r + 1'b1;
      end
    end
  end

  // grant time memory; read address looks ahead so a pop sees the next entry
  logic [TIME_BITS-1:0] mem [RECORD_DEPTH];
  logic [TIME_BITS-1:0] rd_data_r;

  assign rd_addr = cmd.pop ? oldest_inc : oldest_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[tail_r] <= now_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // stale threshold: entry t is stale when t <= now - window and now >= window
  logic [TIME_BITS:0]   diff;
  logic [TIME_BITS-1:0] thr_r;
  logic                 thr_ok_r;

  assign diff = {1'b0, now_r} - {{(TIME_BITS - 31){1'b0}}, window_ms_r};

  always_ff @(posedge clk) begin
    if (cmd.set_thr) begin
      thr_r    <= diff[TIME_BITS-1:0];
      thr_ok_r <= !diff[TIME_BITS];
    end
  end

  // limit check
  logic [LIM_W-1:0] limit;

  assign limit = (LIM_W'(max_restarts_r) > LIM_W'(RECORD_DEPTH)) ?
                 LIM_W'(RECORD_DEPTH) : LIM_W'(max_restarts_r);

  // backoff: base times multiplier, then cap and scale to ms
  logic [2:0]         mult_idx;
  logic [20:0]        mul_r;
  logic [15:0]        capped;
  logic               res_grant_r;
  logic [DELAY_W-1:0] res_delay_r;

  assign mult_idx = (grants_r < 16'(MULT_LAST)) ? grants_r[2:0] : 3'(MULT_LAST);
  assign capped   = (mul_r > {5'b0, max_backoff_r}) ? max_backoff_r : mul_r[15:0];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mul_r <= 21'(backoff_r) * 21'(backoff_mult(mult_idx));
    end
    if (cmd.clear || cmd.refuse) begin
      res_grant_r <= 1'b0;
      res_delay_r <= '0;
    end else if (cmd.commit) begin
      res_grant_r <= 1'b1;
      res_delay_r <= DELAY_W'(capped) * DELAY_W'(MS_PER_S);
    end
  end

  // output register
  out_req_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.granted       <= res_grant_r;
      out_r.delay_ms      <= res_delay_r;
      out_r.attempt_count <= grants_r;
    end
  end

  assign out_data = out_r;

  assign status.op_clear   = (op_t'(op_r) == OP_CLEAR);
  assign status.prune_done = (count_r == '0) || !thr_ok_r || (rd_data_r > thr_r);
  assign status.full       = (LIM_W'(count_r) >= limit);

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from empty ring");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(count_r) <= LIM_W'(RECORD_DEPTH))
    else $error("ring count above depth");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> LIM_W'(count_r) < LIM_W'(RECORD_DEPTH))
    else $error("grant stored into full ring");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0 && grants_r == '0)
    else $error("clear left history behind");
`endif

endmodule

>>> sv/restart_budget_backoff.sv
// restart budget limiter with a sliding window and exponential backoff.
// each request carries a millisecond time stamp; grant times are kept in a ring
// of RECORD_DEPTH entries. a restart request first drops every stored time t with
// t + window_ms <= now_ms, one entry per cycle, then is refused when the ring
// already holds min(max_restarts, RECORD_DEPTH) grants, else granted with
// delay_ms = min(backoff_seconds * {1,2,4,8,15,30}[min(count,5)],
// max_backoff_seconds) * 1000. a clear request empties the ring and zeroes the
// consecutive grant count. one request is handled at a time: a clear goes from
// acceptance straight to the result, while a restart request first sets the
// window threshold, drops its 0 to RECORD_DEPTH stale entries, is decided and,
// when granted, has its delay scaled before the result is loaded.
// the next request is accepted as soon as the result is in the output register,
// while it waits to be taken.
// configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
// write it only while idle, the block does not enforce this. the grant time
// memory needs no clearing after reset. depends on rbb_pkg, rbb_ctrl and rbb_dpath.

module restart_budget_backoff
  import rbb_pkg::*;
#(
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_req_t                in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_req_t               out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: owns the handshakes and steps the datapath
  rbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: ring, threshold, backoff arithmetic, result register
  rbb_dpath #(
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
